// File: rtl/pbm_pkg.sv
package pbm_pkg;

  // Channel limits and the percent scale of the alpha mix.
  localparam logic [7:0] ChMax   = 8'd255;
  localparam logic [6:0] PctFull = 7'd100;

  // Division by 100 as a multiply by ceil(2^20 / 100) and a shift by 20.
  // This is exact for every sum below 43690, and a mix sum never exceeds 25500.
  localparam int unsigned DivShift = 20;
  localparam logic [13:0] DivRecip = 14'd10486;

  // Configuration register indexes.
  localparam logic CfgBlendMode = 1'b0;
  localparam logic CfgAlpha     = 1'b1;

  // Blend modes.
  typedef enum logic [2:0] {
    MODE_MULTIPLY    = 3'd0,
    MODE_SCREEN      = 3'd1,
    MODE_OVERLAY     = 3'd2,
    MODE_DARKEN      = 3'd3,
    MODE_LIGHTEN     = 3'd4,
    MODE_DIFFERENCE  = 3'd5,
    MODE_ADDITIVE    = 3'd6,
    MODE_SUBTRACTIVE = 3'd7
  } blend_mode_e;

  // One input transfer: the base pixel and the top pixel.
  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
  } pbm_in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pbm_out_t;

endpackage

// File: rtl/pixel_blend_mode_unit_core.sv
// A pixel taken with start is registered through the stages below and appears on result_o,
// marked by result_valid_o, for one cycle.
// Throughput: one pixel per cycle; four register stages (products, blend select,
// alpha mix, divide by 100). busy stays low since the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the blend mode
// to multiply and alpha to 100 percent.
module pixel_blend_mode_unit_core
  import pbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  pbm_in_t    pixel_i,
  output logic       result_valid_o,
  output pbm_out_t   result_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_wdata_i
);

  localparam int unsigned NumCh = 3;

  // The pipeline never holds off new pixels.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Configuration registers.
  blend_mode_e mode_q;
  logic [6:0]  alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MULTIPLY;
      alpha_q <= PctFull;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBlendMode: mode_q  <= blend_mode_e'(cfg_wdata_i[2:0]);
        CfgAlpha:     alpha_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Alpha values above 100 act as 100.
  logic [6:0] alpha_sat;
  assign alpha_sat = (alpha_q > PctFull) ? PctFull : alpha_q;

  // Split the input pixel into channel lanes: 0 red, 1 green, 2 blue.
  logic [7:0] base_in [NumCh];
  logic [7:0] top_in  [NumCh];
  assign base_in[0] = pixel_i.base_red;
  assign base_in[1] = pixel_i.base_green;
  assign base_in[2] = pixel_i.base_blue;
  assign top_in[0]  = pixel_i.top_red;
  assign top_in[1]  = pixel_i.top_green;
  assign top_in[2]  = pixel_i.top_blue;

  // Stage A: the two 8x8 products that multiply, screen and overlay need.
  logic        vld_a_q;
  blend_mode_e mode_a_q;
  logic [6:0]  alpha_a_q;
  logic [7:0]  base_a_q [NumCh];
  logic [7:0]  top_a_q  [NumCh];
  logic [15:0] mul_a_q  [NumCh];
  logic [15:0] scr_a_q  [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_a_q  <= mode_q;
      alpha_a_q <= alpha_sat;
      for (int c = 0; c < NumCh; c++) begin
        base_a_q[c] <= base_in[c];
        top_a_q[c]  <= top_in[c];
        mul_a_q[c]  <= {8'd0, base_in[c]} * {8'd0, top_in[c]};
        scr_a_q[c]  <= {8'd0, ~base_in[c]} * {8'd0, ~top_in[c]};
      end
    end
  end

  // Stage B: select the blend result of each channel.
  logic [7:0] blend_d [NumCh];

  always_comb begin
    logic [8:0] sum9;
    for (int c = 0; c < NumCh; c++) begin
      sum9 = {1'b0, base_a_q[c]} + {1'b0, top_a_q[c]};
      case (mode_a_q)
        MODE_MULTIPLY:    blend_d[c] = mul_a_q[c][15:8];
        MODE_SCREEN:      blend_d[c] = ChMax - scr_a_q[c][15:8];
        MODE_OVERLAY: begin
          if (!base_a_q[c][7]) begin
            blend_d[c] = mul_a_q[c][14:7];
          end else begin
            blend_d[c] = ChMax - scr_a_q[c][14:7];
          end
        end
        MODE_DARKEN:
          blend_d[c] = (base_a_q[c] < top_a_q[c]) ? base_a_q[c] : top_a_q[c];
        MODE_LIGHTEN:
          blend_d[c] = (base_a_q[c] > top_a_q[c]) ? base_a_q[c] : top_a_q[c];
        MODE_DIFFERENCE:
          blend_d[c] = (base_a_q[c] > top_a_q[c]) ? (base_a_q[c] - top_a_q[c])
                                                  : (top_a_q[c] - base_a_q[c]);
        MODE_ADDITIVE:    blend_d[c] = sum9[8] ? ChMax : sum9[7:0];
        MODE_SUBTRACTIVE: begin
          if (sum9 > {1'b0, ChMax}) begin
            blend_d[c] = 8'(sum9 - {1'b0, ChMax});
          end else begin
            blend_d[c] = 8'd0;
          end
        end
        default:          blend_d[c] = 8'd0;
      endcase
    end
  end

  logic       vld_b_q;
  logic [6:0] alpha_b_q;
  logic [7:0] base_b_q  [NumCh];
  logic [7:0] blend_b_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_a_q) begin
      alpha_b_q <= alpha_a_q;
      for (int c = 0; c < NumCh; c++) begin
        base_b_q[c]  <= base_a_q[c];
        blend_b_q[c] <= blend_d[c];
      end
    end
  end

  // Stage C: weighted sum alpha*blend + (100-alpha)*base, at most 25500.
  logic [6:0]  inv_alpha;
  logic [14:0] sum_d [NumCh];
  assign inv_alpha = PctFull - alpha_b_q;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      sum_d[c] = ({8'd0, alpha_b_q} * {7'd0, blend_b_q[c]})
               + ({8'd0, inv_alpha} * {7'd0, base_b_q[c]});
    end
  end

  logic        vld_c_q;
  logic [14:0] sum_c_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_b_q) begin
      for (int c = 0; c < NumCh; c++) begin
        sum_c_q[c] <= sum_d[c];
      end
    end
  end

  // Stage D: divide by 100 through the reciprocal; the quotient starts at bit 20.
  logic        vld_d_q;
  logic [28:0] quo_d_q [NumCh];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_c_q) begin
      for (int c = 0; c < NumCh; c++) begin
        quo_d_q[c] <= {14'd0, sum_c_q[c]} * {15'd0, DivRecip};
      end
    end
  end

  // Result ports.
  assign result_valid_o    = vld_d_q;
  assign result_o.out_red   = quo_d_q[0][DivShift +: 8];
  assign result_o.out_green = quo_d_q[1][DivShift +: 8];
  assign result_o.out_blue  = quo_d_q[2][DivShift +: 8];

`ifndef SYNTHESIS
  // A result only leaves for a pixel that was taken with start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, 4))
    else $error("result without a pixel transfer four cycles earlier");

  // Alpha carried with a pixel is always saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q |-> (alpha_a_q <= PctFull))
    else $error("unsaturated alpha in the pipeline");

  // Zero alpha gives one hundred times the base channel before the divide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && (alpha_b_q == 7'd0))
      |=> (sum_c_q[0] == 15'($past(base_b_q[0]) * 15'd100)))
    else $error("zero alpha mix differs from base");

  // Full alpha gives the pure blend result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && (alpha_b_q == PctFull))
      |=> (sum_c_q[0] == 15'($past(blend_b_q[0]) * 15'd100)))
    else $error("full alpha mix differs from blend");

  // The divided mix never leaves the channel range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_d_q |-> (quo_d_q[0][28] == 1'b0))
    else $error("mix quotient out of channel range");
`endif

endmodule
